// ===== rtl/arp_pkg.sv =====
`timescale 1ns / 1ps
// arp_pkg: shared types and constants for the aarch64 relocation patcher
// no dependencies; imported by arp_calc, aarch64_reloc_patcher and the bench files

package arp_pkg;

  // relocation kinds
  localparam logic [3:0] CMD_ABS64     = 4'd0;
  localparam logic [3:0] CMD_ABS32     = 4'd1;
  localparam logic [3:0] CMD_MOVW_G0   = 4'd2;
  localparam logic [3:0] CMD_MOVW_G1   = 4'd3;
  localparam logic [3:0] CMD_MOVW_G2   = 4'd4;
  localparam logic [3:0] CMD_MOVW_G3   = 4'd5;
  localparam logic [3:0] CMD_ADRP      = 4'd6;
  localparam logic [3:0] CMD_ADD_LO12  = 4'd7;
  localparam logic [3:0] CMD_JUMP26    = 4'd8;
  localparam logic [3:0] CMD_CALL26    = 4'd9;
  localparam logic [3:0] CMD_GOT_PAGE  = 4'd10;
  localparam logic [3:0] CMD_GOT_LO12  = 4'd11;
  localparam logic [3:0] CMD_COPY      = 4'd12;
  localparam logic [3:0] CMD_GLOB_DAT  = 4'd13;
  localparam logic [3:0] CMD_JUMP_SLOT = 4'd14;

  // write sizes
  localparam logic [1:0] WS_NONE = 2'd0;
  localparam logic [1:0] WS_32   = 2'd1;
  localparam logic [1:0] WS_64   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;

  // instruction field masks
  localparam logic [31:0] MOVW_KEEP  = 32'hffe0001f;
  localparam logic [31:0] ADRP_KEEP  = 32'h9f00001f;
  localparam logic [31:0] ADRP_HI    = 32'h001ffffc;
  localparam logic [31:0] ADD_KEEP   = 32'hffc003ff;
  localparam logic [31:0] BRANCH_OP  = 32'h14000000;
  localparam logic [31:0] BRANCH_IMM = 32'h03ffffff;
  localparam logic [31:0] LDR_KEEP   = 32'hfff803ff;
  localparam logic [31:0] LDR_OFF    = 32'h00000ff8;
  localparam logic [63:0] BRANCH_OK  = 64'h000000000ffffffc;
  localparam logic [31:0] BL_BIT     = 32'h80000000;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] old_word;
    logic [63:0] place_address;
    logic [63:0] symbol_value;
    logic [63:0] got_entry_address;
    logic [63:0] addend;
  } reloc_in_t;

  typedef struct packed {
    logic [63:0] new_value;
    logic [1:0]  write_size;
    logic [1:0]  status;
  } reloc_out_t;

endpackage

// ===== rtl/arp_calc.sv =====
`timescale 1ns / 1ps
// arp_calc: combinational patch computation for one relocation record
// depends on arp_pkg

module arp_calc import arp_pkg::*; (
  input  reloc_in_t  rec,
  output reloc_out_t res
);

  logic [51:0] page_target;
  logic [52:0] page_delta;
  logic        page_bad;
  logic [31:0] adrp_word;
  logic [63:0] br_delta;
  logic [63:0] br_biased;
  logic        br_bad;
  logic [31:0] br_word;
  logic [1:0]  movw_group;
  logic [15:0] movw_chunk;
  logic [31:0] movw_word;
  logic [31:0] add_word;
  logic [31:0] ldr_word;
  logic [63:0] dyn_value;

  // page delta is exact in 53 bits, in range when bits 52..20 agree
  assign page_target = (rec.cmd == CMD_ADRP) ? rec.symbol_value[63:12]
                                             : rec.got_entry_address[63:12];
  assign page_delta  = {1'b0, page_target} - {1'b0, rec.place_address[63:12]};
  assign page_bad    = !((&page_delta[52:20]) || !(|page_delta[52:20]));
  assign adrp_word   = (rec.old_word & ADRP_KEEP)
                     | ((({11'd0, page_delta[20:0]}) & ADRP_HI) << 3)
                     | {1'b0, page_delta[1:0], 29'd0};

  assign br_delta  = rec.symbol_value - rec.place_address;
  assign br_biased = br_delta + 64'h0000000008000000;
  assign br_bad    = |(br_biased & ~BRANCH_OK);
  assign br_word   = BRANCH_OP | (br_delta[33:2] & BRANCH_IMM)
                   | ((rec.cmd == CMD_CALL26) ? BL_BIT : 32'd0);

  assign movw_group = rec.cmd[1:0] - 2'd2;
  always_comb begin
    case (movw_group)
      2'd0:    movw_chunk = rec.symbol_value[15:0];
      2'd1:    movw_chunk = rec.symbol_value[31:16];
      2'd2:    movw_chunk = rec.symbol_value[47:32];
      default: movw_chunk = rec.symbol_value[63:48];
    endcase
  end
  assign movw_word = (rec.old_word & MOVW_KEEP) | {11'd0, movw_chunk, 5'd0};

  assign add_word  = (rec.old_word & ADD_KEEP) | {10'd0, rec.symbol_value[11:0], 10'd0};
  assign ldr_word  = (rec.old_word & LDR_KEEP)
                   | (({20'd0, rec.got_entry_address[11:0]} & LDR_OFF) << 7);
  assign dyn_value = rec.symbol_value - rec.addend;

  always_comb begin
    res.new_value  = 64'd0;
    res.write_size = WS_NONE;
    res.status     = ST_OK;
    unique case (rec.cmd) inside
      CMD_ABS64: begin
        res.new_value  = rec.symbol_value;
        res.write_size = WS_64;
      end
      CMD_ABS32: begin
        res.new_value  = {32'd0, rec.symbol_value[31:0]};
        res.write_size = WS_32;
      end
      CMD_MOVW_G0, CMD_MOVW_G1, CMD_MOVW_G2, CMD_MOVW_G3: begin
        res.new_value  = {32'd0, movw_word};
        res.write_size = WS_32;
      end
      CMD_ADRP, CMD_GOT_PAGE: begin
        if (page_bad) begin
          res.status = ST_RANGE;
        end else begin
          res.new_value  = {32'd0, adrp_word};
          res.write_size = WS_32;
        end
      end
      CMD_ADD_LO12: begin
        res.new_value  = {32'd0, add_word};
        res.write_size = WS_32;
      end
      CMD_JUMP26, CMD_CALL26: begin
        if (br_bad) begin
          res.status = ST_RANGE;
        end else begin
          res.new_value  = {32'd0, br_word};
          res.write_size = WS_32;
        end
      end
      CMD_GOT_LO12: begin
        res.new_value  = {32'd0, ldr_word};
        res.write_size = WS_32;
      end
      CMD_COPY: begin
        res.write_size = WS_NONE;
      end
      CMD_GLOB_DAT, CMD_JUMP_SLOT: begin
        res.new_value  = dyn_value;
        res.write_size = WS_64;
      end
      default: begin
        res.status = ST_UNSUP;
      end
    endcase
  end

endmodule

// ===== rtl/aarch64_reloc_patcher.sv =====
`timescale 1ns / 1ps
// aarch64_reloc_patcher: top level, input register, patch logic, result register
// depends on arp_pkg and arp_calc
//
//   channel | ports                          | payload
//   --------+--------------------------------+------------
//   input   | in_valid, in_stall, in_data    | reloc_in_t
//   result  | out_valid, out_stall, out_data | reloc_out_t
//
// one transaction per cycle sustained while out_stall stays low; an accepted record
// goes into the input register, arp_calc patches it and the result register holds
// the outcome until taken (input register, then result register after arp_calc)
// reset clears both valid flags; payload registers are not reset
// a stalled result holds; the input register drains into the result register
// whenever that register is empty or being taken, so in_stall only rises when both are full

module aarch64_reloc_patcher import arp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  reloc_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output reloc_out_t out_data
);

  logic       rec_valid_r;
  logic       rec_valid_nxt;
  reloc_in_t  rec_r;
  logic       res_valid_r;
  logic       res_valid_nxt;
  reloc_out_t res_r;
  reloc_out_t res_calc;
  logic       res_load;
  logic       rec_load;

  arp_calc u_calc (
    .rec (rec_r),
    .res (res_calc)
  );

  assign res_load = !res_valid_r || !out_stall;
  assign in_stall = rec_valid_r && !res_load;
  assign rec_load = in_valid && !in_stall;

  always_comb begin
    rec_valid_nxt = rec_valid_r;
    res_valid_nxt = res_valid_r;
    if (res_load) begin
      res_valid_nxt = rec_valid_r;
    end
    if (rec_load) begin
      rec_valid_nxt = 1'b1;
    end else if (res_load) begin
      rec_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      rec_valid_r <= rec_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_load) begin
      rec_r <= in_data;
    end
    if (res_load && rec_valid_r) begin
      res_r <= res_calc;
    end
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

endmodule

// ===== bench/reloc_patch_checker.sv =====
`timescale 1ns / 1ps
// reloc_patch_checker: watches both channels of aarch64_reloc_patcher, predicts each
// patched value and compares results field by field; depends on arp_pkg

module reloc_patch_checker import arp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  reloc_in_t  in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  reloc_out_t out_data,
  output int         errors,
  output int         outstanding
);

  localparam int PRINT_CAP = 40;

  reloc_out_t expected_patches[$];

  initial begin
    errors = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errors < PRINT_CAP) begin
      $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
    end
    errors++;
  endtask

  function automatic reloc_out_t predict_patch(input reloc_in_t r);
    reloc_out_t res;
    logic [63:0] shifted;
    logic [63:0] target;
    logic [63:0] page_delta;
    logic [63:0] delta;
    logic [31:0] w;
    res.new_value  = '0;
    res.write_size = WS_NONE;
    res.status     = ST_OK;
    case (r.cmd)
      CMD_ABS64: begin
        res.new_value  = r.symbol_value;
        res.write_size = WS_64;
      end
      CMD_ABS32: begin
        res.new_value  = {32'd0, r.symbol_value[31:0]};
        res.write_size = WS_32;
      end
      CMD_MOVW_G0, CMD_MOVW_G1, CMD_MOVW_G2, CMD_MOVW_G3: begin
        shifted = r.symbol_value >> (16 * (r.cmd - CMD_MOVW_G0));
        w = (r.old_word & MOVW_KEEP) | {11'd0, shifted[15:0], 5'd0};
        res.new_value  = {32'd0, w};
        res.write_size = WS_32;
      end
      CMD_ADRP, CMD_GOT_PAGE: begin
        target = (r.cmd == CMD_ADRP) ? r.symbol_value : r.got_entry_address;
        page_delta = (target >> 12) - (r.place_address >> 12);
        if (((page_delta + 64'h100000) >> 21) != 64'd0) begin
          res.status = ST_RANGE;
        end else begin
          w = (r.old_word & ADRP_KEEP) | ((page_delta[31:0] & ADRP_HI) << 3) |
              {1'b0, page_delta[1:0], 29'd0};
          res.new_value  = {32'd0, w};
          res.write_size = WS_32;
        end
      end
      CMD_ADD_LO12: begin
        w = (r.old_word & ADD_KEEP) | {10'd0, r.symbol_value[11:0], 10'd0};
        res.new_value  = {32'd0, w};
        res.write_size = WS_32;
      end
      CMD_JUMP26, CMD_CALL26: begin
        delta = r.symbol_value - r.place_address;
        // reach of 2^27 bytes either way, word aligned
        if (((delta + 64'h8000000) & ~BRANCH_OK) != 64'd0) begin
          res.status = ST_RANGE;
        end else begin
          w = BRANCH_OP | (delta[33:2] & BRANCH_IMM);
          if (r.cmd == CMD_CALL26) begin
            w = w | BL_BIT;
          end
          res.new_value  = {32'd0, w};
          res.write_size = WS_32;
        end
      end
      CMD_GOT_LO12: begin
        w = (r.old_word & LDR_KEEP) | {13'd0, r.got_entry_address[11:3], 10'd0};
        res.new_value  = {32'd0, w};
        res.write_size = WS_32;
      end
      CMD_COPY: begin
      end
      CMD_GLOB_DAT, CMD_JUMP_SLOT: begin
        res.new_value  = r.symbol_value - r.addend;
        res.write_size = WS_64;
      end
      default: begin
        res.status = ST_UNSUP;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    reloc_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_patches.size() == 0) begin
          report_mismatch("result with no transaction pending", out_data.new_value, '0);
        end else begin
          want = expected_patches.pop_front();
          if (out_data.new_value !== want.new_value) begin
            report_mismatch("new_value", out_data.new_value, want.new_value);
          end
          if (out_data.write_size !== want.write_size) begin
            report_mismatch("write_size", {62'd0, out_data.write_size},
                            {62'd0, want.write_size});
          end
          if (out_data.status !== want.status) begin
            report_mismatch("status", {62'd0, out_data.status}, {62'd0, want.status});
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_patches.push_back(predict_patch(in_data));
      end
    end
    outstanding = expected_patches.size();
  end

endmodule

// ===== bench/tb_aarch64_reloc_patcher.sv =====
`timescale 1ns / 1ps
// tb_aarch64_reloc_patcher: stimulus and verdict for aarch64_reloc_patcher
// depends on arp_pkg, the rtl and reloc_patch_checker

module tb_aarch64_reloc_patcher;
  import arp_pkg::*;

  localparam logic [3:0] CMD_UNKNOWN = 4'd15;
  localparam int N_RANDOM     = 880;
  localparam int HOLD_CYCLES  = 40;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int IDLE_PCT     = 19;
  localparam logic [63:0] PLACE = 64'h0000_0040_0000_1000;
  localparam logic [63:0] ONES  = 64'hffff_ffff_ffff_ffff;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  reloc_in_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  reloc_out_t out_data;

  int   errors;
  int   outstanding;
  int   quiet_cycles = 0;
  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  logic hold_req = 1'b0;

  always #5 clk = ~clk;

  aarch64_reloc_patcher u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  reloc_patch_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side back-pressure
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= rx_idle_on && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] sign_extend(input logic [63:0] v, input int k);
    return $signed(v << (64 - k)) >>> (64 - k);
  endfunction

  function automatic reloc_in_t make_reloc(input logic [3:0] cmd, input logic [31:0] word,
                                           input logic [63:0] place, input logic [63:0] sym,
                                           input logic [63:0] got, input logic [63:0] addend);
    reloc_in_t r;
    r.cmd               = cmd;
    r.old_word          = word;
    r.place_address     = place;
    r.symbol_value      = sym;
    r.got_entry_address = got;
    r.addend            = addend;
    return r;
  endfunction

  // mostly offsets near the legal reach so that both sides of each range check are hit
  function automatic reloc_in_t random_reloc();
    reloc_in_t r;
    logic [63:0] d;
    r = make_reloc(4'($urandom_range(0, 15)), $urandom, rand64(), rand64(), rand64(),
                   rand64());
    if ($urandom_range(0, 9) < 8) begin
      case (r.cmd)
        CMD_JUMP26, CMD_CALL26: begin
          d = sign_extend(rand64(), $urandom_range(1, 29));
          if ($urandom_range(0, 9) != 0) begin
            d[1:0] = 2'b00;
          end
          r.symbol_value = r.place_address + d;
        end
        CMD_ADRP: begin
          d = sign_extend(rand64(), $urandom_range(1, 22));
          r.symbol_value = {r.place_address[63:12] + d[51:0], r.symbol_value[11:0]};
        end
        CMD_GOT_PAGE: begin
          d = sign_extend(rand64(), $urandom_range(1, 22));
          r.got_entry_address = {r.place_address[63:12] + d[51:0],
                                 r.got_entry_address[11:0]};
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  task automatic send_reloc(input reloc_in_t r);
    if (tx_idle_on && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_reloc(make_reloc(CMD_ABS64, 32'h0, PLACE, ONES, ONES, ONES));
    send_reloc(make_reloc(CMD_ABS32, 32'h0, PLACE, ONES, 64'h0, 64'h0));
    send_reloc(make_reloc(CMD_MOVW_G0, 32'hffff_ffff, PLACE, 64'h1234_5678_9abc_def0, 0, 0));
    send_reloc(make_reloc(CMD_MOVW_G1, 32'h0, PLACE, 64'h1234_5678_9abc_def0, 0, 0));
    send_reloc(make_reloc(CMD_MOVW_G2, 32'hffff_ffff, PLACE, 64'h1234_5678_9abc_def0, 0, 0));
    send_reloc(make_reloc(CMD_MOVW_G3, 32'h0, PLACE, ONES, 0, 0));
    // page reach at both ends and one page past each
    send_reloc(make_reloc(CMD_ADRP, 32'hffff_ffff, PLACE, PLACE + 64'hffff_f000, 0, 0));
    send_reloc(make_reloc(CMD_ADRP, 32'h0, PLACE, PLACE - 64'h1_0000_0000, 0, 0));
    send_reloc(make_reloc(CMD_ADRP, 32'hffff_ffff, PLACE, PLACE + 64'h1_0000_0000, 0, 0));
    send_reloc(make_reloc(CMD_ADRP, 32'h0, PLACE, PLACE - 64'h1_0000_1000, 0, 0));
    send_reloc(make_reloc(CMD_ADD_LO12, 32'h0, PLACE, 64'hfff, 0, 0));
    // branch reach, misalignment and call bit
    send_reloc(make_reloc(CMD_JUMP26, 32'h0, PLACE, PLACE + 64'h7ff_fffc, 0, 0));
    send_reloc(make_reloc(CMD_JUMP26, 32'h0, PLACE, PLACE - 64'h800_0000, 0, 0));
    send_reloc(make_reloc(CMD_JUMP26, 32'h0, PLACE, PLACE + 64'h800_0000, 0, 0));
    send_reloc(make_reloc(CMD_CALL26, 32'h0, PLACE, PLACE + 64'h2, 0, 0));
    send_reloc(make_reloc(CMD_CALL26, 32'h0, PLACE, PLACE - 64'h4, 0, 0));
    send_reloc(make_reloc(CMD_CALL26, 32'h0, PLACE, PLACE - 64'h800_0004, 0, 0));
    send_reloc(make_reloc(CMD_GOT_PAGE, 32'hffff_ffff, PLACE, 0, PLACE + 64'h5000, 0));
    send_reloc(make_reloc(CMD_GOT_PAGE, 32'h0, ONES, ONES, 64'h0, 0));
    send_reloc(make_reloc(CMD_GOT_LO12, 32'hffff_ffff, PLACE, 0, ONES, 0));
    send_reloc(make_reloc(CMD_COPY, 32'hffff_ffff, ONES, ONES, ONES, ONES));
    send_reloc(make_reloc(CMD_GLOB_DAT, 32'h0, PLACE, 64'h5, 0, 64'h7));
    send_reloc(make_reloc(CMD_JUMP_SLOT, 32'h0, PLACE, ONES, 0, 64'h1));
    send_reloc(make_reloc(CMD_UNKNOWN, 32'hffff_ffff, ONES, ONES, ONES, ONES));
    send_reloc(make_reloc(CMD_ABS64, 32'h0, 64'h0, 64'h0, 64'h0, 64'h0));
    wait_results_drained();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 150) begin
        hold_req = 1'b1;
      end
      if (i == 300) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      if (i == 500) begin
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
      end
      if (i == 700) begin
        wait_results_drained();
      end
      send_reloc(random_reloc());
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
